// ===== hdl/wav_pcm16_stream_parser_defines.svh =====
// Assertion helpers shared by the parser modules.
`ifndef WAV_PCM16_STREAM_PARSER_DEFINES_SVH
`define WAV_PCM16_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define WPSP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wpsp assertion failed");

// Next-cycle implication, held off during reset.
`define WPSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wpsp assertion failed");

`endif

// ===== hdl/wpsp_pkg.sv =====
package wpsp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF    = 3'd1;
  localparam logic [2:0] ST_NOT_WAVE    = 3'd2;
  localparam logic [2:0] ST_NO_FMT      = 3'd3;
  localparam logic [2:0] ST_NO_DATA     = 3'd4;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } byte_item_t;

  typedef struct packed {
    logic               is_status;
    logic signed [15:0] sample_value;
    logic               chunk_start;
    logic [2:0]         status_code;
    logic [15:0]        channel_count;
    logic [31:0]        sample_rate_hz;
    logic [31:0]        total_samples;
    logic               last_result;
  } result_item_t;

  // What one byte leaves for the back end: a sample, a status, or both.
  typedef struct packed {
    logic               has_sample;
    logic signed [15:0] sample_value;
    logic               chunk_start;
    logic               has_status;
    logic [2:0]         status_code;
    logic [15:0]        channel_count;
    logic [31:0]        sample_rate_hz;
    logic [31:0]        total_samples;
  } event_t;

endpackage

// ===== hdl/wpsp_front.sv =====
module wpsp_front
  import wpsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  byte_item_t item,
  output logic       push,
  output event_t     ev
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHDR,
    PH_BODY,
    PH_PAD,
    PH_DEAD
  } phase_t;

  typedef enum logic [1:0] {
    CT_OTHER,
    CT_FMT,
    CT_DATA
  } chunk_t;

  phase_t      phase, phase_next;
  logic [3:0]  byte_position, byte_position_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [4:0]  body_offset, body_offset_next;   // saturates at 16
  chunk_t      chunk_type, chunk_type_next;
  logic [2:0]  header_error, header_error_next;
  logic [15:0] format_code, format_code_next;
  logic [15:0] channels_seen, channels_seen_next;
  logic [31:0] rate_seen, rate_seen_next;
  logic [15:0] bits_seen, bits_seen_next;
  logic        fmt_found, fmt_found_next;
  logic        data_found, data_found_next;
  logic        hold_valid, hold_valid_next;
  logic [7:0]  hold_byte, hold_byte_next;
  logic [31:0] sample_counter, sample_counter_next;
  logic [7:0]  b;

  assign b = item.data_byte;

  always_comb begin
    phase_next          = phase;
    byte_position_next  = byte_position;
    tag_shift_next      = tag_shift;
    chunk_length_next   = chunk_length;
    bytes_left_next     = bytes_left;
    body_offset_next    = body_offset;
    chunk_type_next     = chunk_type;
    header_error_next   = header_error;
    format_code_next    = format_code;
    channels_seen_next  = channels_seen;
    rate_seen_next      = rate_seen;
    bits_seen_next      = bits_seen;
    fmt_found_next      = fmt_found;
    data_found_next     = data_found;
    hold_valid_next     = hold_valid;
    hold_byte_next      = hold_byte;
    sample_counter_next = sample_counter;
    ev                  = '0;

    unique case (phase)
      PH_HEADER: begin
        tag_shift_next = {tag_shift[23:0], b};
        if (byte_position == 4'd3 && tag_shift_next != TAG_RIFF) begin
          header_error_next = ST_NOT_RIFF;
        end
        if (byte_position == 4'd11) begin
          if (header_error_next == ST_OK && tag_shift_next != TAG_WAVE) begin
            header_error_next = ST_NOT_WAVE;
          end
          phase_next         = (header_error_next != ST_OK) ? PH_DEAD : PH_CHDR;
          byte_position_next = '0;
        end else begin
          byte_position_next = byte_position + 4'd1;
        end
      end
      PH_CHDR: begin
        if (byte_position < 4'd4) begin
          tag_shift_next = {tag_shift[23:0], b};
          if (byte_position == 4'd3) begin
            priority if (tag_shift_next == TAG_FMT) begin
              chunk_type_next = CT_FMT;
            end else if (tag_shift_next == TAG_DATA) begin
              chunk_type_next = CT_DATA;
            end else begin
              chunk_type_next = CT_OTHER;
            end
          end
        end else begin
          chunk_length_next = {b, chunk_length[31:8]};
        end
        if (byte_position == 4'd7) begin
          byte_position_next = '0;
          bytes_left_next    = chunk_length_next;
          body_offset_next   = '0;
          if (chunk_type_next == CT_DATA) begin
            data_found_next     = 1'b1;
            sample_counter_next = '0;
            hold_valid_next     = 1'b0;
          end
          phase_next = (chunk_length_next == '0) ? PH_CHDR : PH_BODY;
        end else begin
          byte_position_next = byte_position + 4'd1;
        end
      end
      PH_BODY: begin
        if (chunk_type == CT_FMT && chunk_length >= 32'd16 && !body_offset[4]) begin
          unique case (body_offset[3:0])
            4'd0:  format_code_next[7:0]    = b;
            4'd1:  format_code_next[15:8]   = b;
            4'd2:  channels_seen_next[7:0]  = b;
            4'd3:  channels_seen_next[15:8] = b;
            4'd4:  rate_seen_next[7:0]      = b;
            4'd5:  rate_seen_next[15:8]     = b;
            4'd6:  rate_seen_next[23:16]    = b;
            4'd7:  rate_seen_next[31:24]    = b;
            4'd14: bits_seen_next[7:0]      = b;
            4'd15: begin
              bits_seen_next[15:8] = b;
              fmt_found_next       = 1'b1;
            end
            default: ;
          endcase
        end else if (chunk_type == CT_DATA) begin
          if (hold_valid) begin
            ev.has_sample       = 1'b1;
            ev.sample_value     = signed'({b, hold_byte});
            ev.chunk_start      = (sample_counter == '0);
            sample_counter_next = sample_counter + 32'd1;
            hold_valid_next     = 1'b0;
          end else begin
            hold_valid_next = 1'b1;
            hold_byte_next  = b;
          end
        end
        if (!body_offset[4]) begin
          body_offset_next = body_offset + 5'd1;
        end
        bytes_left_next = bytes_left - 32'd1;
        if (bytes_left == 32'd1) begin
          phase_next = chunk_length[0] ? PH_PAD : PH_CHDR;
        end
      end
      PH_PAD: begin
        phase_next         = PH_CHDR;
        byte_position_next = '0;
      end
      default: ;
    endcase

    if (item.end_of_file) begin
      ev.has_status     = 1'b1;
      ev.channel_count  = channels_seen_next;
      ev.sample_rate_hz = rate_seen_next;
      ev.total_samples  = sample_counter_next;
      priority if (phase_next == PH_HEADER) begin
        ev.status_code = ST_NOT_RIFF;
      end else if (phase_next == PH_DEAD) begin
        ev.status_code = header_error_next;
      end else if (!fmt_found_next) begin
        ev.status_code = ST_NO_FMT;
      end else if (!data_found_next) begin
        ev.status_code = ST_NO_DATA;
      end else if (format_code_next != 16'd1 || bits_seen_next != 16'd16) begin
        ev.status_code = ST_UNSUPPORTED;
      end else begin
        ev.status_code = ST_OK;
      end
    end
  end

  assign push = accept && (ev.has_sample || ev.has_status);

  always_ff @(posedge clk) begin
    if (rst || (accept && item.end_of_file)) begin
      phase          <= PH_HEADER;
      byte_position  <= '0;
      tag_shift      <= '0;
      chunk_length   <= '0;
      bytes_left     <= '0;
      body_offset    <= '0;
      chunk_type     <= CT_OTHER;
      header_error   <= ST_OK;
      format_code    <= '0;
      channels_seen  <= '0;
      rate_seen      <= '0;
      bits_seen      <= '0;
      fmt_found      <= 1'b0;
      data_found     <= 1'b0;
      hold_valid     <= 1'b0;
      hold_byte      <= '0;
      sample_counter <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      tag_shift      <= tag_shift_next;
      chunk_length   <= chunk_length_next;
      bytes_left     <= bytes_left_next;
      body_offset    <= body_offset_next;
      chunk_type     <= chunk_type_next;
      header_error   <= header_error_next;
      format_code    <= format_code_next;
      channels_seen  <= channels_seen_next;
      rate_seen      <= rate_seen_next;
      bits_seen      <= bits_seen_next;
      fmt_found      <= fmt_found_next;
      data_found     <= data_found_next;
      hold_valid     <= hold_valid_next;
      hold_byte      <= hold_byte_next;
      sample_counter <= sample_counter_next;
    end
  end

endmodule

// ===== hdl/wpsp_queue.sv =====
`include "wav_pcm16_stream_parser_defines.svh"

module wpsp_queue
  import wpsp_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  event_t push_data,
  input  logic   pop,
  output event_t pop_data,
  output logic   full,
  output logic   empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  event_t        entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  `WPSP_ASSERT_NOW(a_no_push_full, clk, rst, push, !full)
  `WPSP_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, !empty)
  `WPSP_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + CW'(1))

endmodule

// ===== hdl/wpsp_back.sv =====
`include "wav_pcm16_stream_parser_defines.svh"

module wpsp_back
  import wpsp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         q_empty,
  input  event_t       q_data,
  output logic         pop,
  output logic         result_valid,
  input  logic         result_ready,
  output result_item_t result_item
);

  event_t cur;
  logic   cur_valid;
  logic   sample_sent;
  logic   show_sample;
  logic   last_of_cur;
  logic   fire;

  assign show_sample  = cur.has_sample && !sample_sent;
  assign last_of_cur  = !show_sample || !cur.has_status;
  assign result_valid = cur_valid;
  assign fire         = result_valid && result_ready;
  assign pop          = !q_empty && (!cur_valid || (fire && last_of_cur));

  always_comb begin
    result_item = '0;
    if (show_sample) begin
      result_item.sample_value = cur.sample_value;
      result_item.chunk_start  = cur.chunk_start;
    end else begin
      result_item.is_status      = 1'b1;
      result_item.status_code    = cur.status_code;
      result_item.channel_count  = cur.channel_count;
      result_item.sample_rate_hz = cur.sample_rate_hz;
      result_item.total_samples  = cur.total_samples;
      result_item.last_result    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid   <= 1'b0;
      sample_sent <= 1'b0;
    end else if (pop) begin
      cur_valid   <= 1'b1;
      sample_sent <= 1'b0;
    end else if (fire) begin
      if (last_of_cur) begin
        cur_valid <= 1'b0;
      end else begin
        sample_sent <= 1'b1;
      end
    end
  end

  `WPSP_ASSERT_NOW(a_cur_not_blank, clk, rst, cur_valid, cur.has_sample || cur.has_status)
  `WPSP_ASSERT_NEXT(a_status_follows, clk, rst, fire && !last_of_cur,
                    result_valid && result_item.is_status)
  `WPSP_ASSERT_NOW(a_status_clean, clk, rst, result_valid && result_item.is_status,
                   result_item.sample_value == '0 && !result_item.chunk_start)

endmodule

// ===== hdl/wav_pcm16_stream_parser.sv =====
// Channel   Handshake                    Payload
// bytes     byte_valid / byte_ready      byte_item   (data_byte, end_of_file)
// results   result_valid / result_ready  result_item (sample or final status)
//
// One byte is taken per cycle while byte_ready is high; a byte that completes a sample and ends the
// file gives two results, which leave one per cycle while result_ready is high.
// The parser updates all of its state in the cycle a byte is taken; results
// reach the port through the event queue and the back end's holding register.
// byte_ready drops only while the QUEUE_DEPTH-entry event queue is full.
// rst is synchronous and clears parser state, queue and output holding.
module wav_pcm16_stream_parser
  import wpsp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  output logic         byte_ready,
  input  byte_item_t   byte_item,
  output logic         result_valid,
  input  logic         result_ready,
  output result_item_t result_item
);

  logic   accept;
  logic   push;
  event_t push_data;
  logic   pop;
  event_t pop_data;
  logic   q_full;
  logic   q_empty;

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;

  wpsp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (byte_item),
    .push   (push),
    .ev     (push_data)
  );

  wpsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  wpsp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (pop_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

endmodule

// ===== tb/tb_wav_pcm16_stream_parser.sv =====
`timescale 1ns / 1ps

module tb_wav_pcm16_stream_parser;
  import wpsp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned RANDOM_BYTES = 600;
  localparam logic [15:0] PCM_FORMAT = 16'd1;
  localparam logic [15:0] PCM_BITS = 16'd16;
  localparam logic [31:0] TAG_LIST = 32'h4C49_5354;

  logic         clk;
  logic         rst = 1'b1;
  logic         byte_valid = 1'b0;
  logic         byte_ready;
  byte_item_t   byte_item = '0;
  logic         result_valid;
  logic         result_ready = 1'b0;
  result_item_t result_item;

  result_item_t parser_outputs[$];

  wav_pcm16_stream_parser dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, parser_outputs.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser mirror: tracks the byte walk and queues the samples and status
  // that each accepted byte must produce.

  typedef enum logic [2:0] {AT_HEADER, AT_CHUNK_HDR, AT_BODY, AT_PAD, AT_DEAD} walk_t;
  typedef enum logic [1:0] {KIND_OTHER, KIND_FMT, KIND_DATA} chunk_kind_t;

  walk_t       walk;
  logic [3:0]  pos;
  logic [31:0] shreg;
  logic [31:0] clen;
  logic [31:0] cleft;
  chunk_kind_t kind;
  logic [2:0]  hdr_err;
  logic [15:0] fcode;
  logic [15:0] fchan;
  logic [31:0] frate;
  logic [15:0] fbits;
  logic        got_fmt;
  logic        got_data;
  logic [8:0]  held;
  logic [31:0] nsamp;

  function automatic void clear_parse();
    walk = AT_HEADER;
    pos = '0;
    shreg = '0;
    clen = '0;
    cleft = '0;
    kind = KIND_OTHER;
    hdr_err = ST_OK;
    fcode = '0;
    fchan = '0;
    frate = '0;
    fbits = '0;
    got_fmt = 1'b0;
    got_data = 1'b0;
    held = '0;
    nsamp = '0;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic eof);
    logic [31:0]  off;
    result_item_t r;
    case (walk)
      AT_HEADER: begin
        shreg = {shreg[23:0], b};
        if (pos == 4'd3 && shreg != TAG_RIFF) hdr_err = ST_NOT_RIFF;
        if (pos == 4'd11) begin
          // a bad RIFF tag wins over a bad WAVE tag
          if (hdr_err == ST_OK && shreg != TAG_WAVE) hdr_err = ST_NOT_WAVE;
          walk = (hdr_err != ST_OK) ? AT_DEAD : AT_CHUNK_HDR;
          pos = '0;
        end else begin
          pos = pos + 4'd1;
        end
      end
      AT_CHUNK_HDR: begin
        if (pos < 4'd4) begin
          shreg = {shreg[23:0], b};
          if (pos == 4'd3)
            kind = (shreg == TAG_FMT) ? KIND_FMT :
                   (shreg == TAG_DATA) ? KIND_DATA : KIND_OTHER;
        end else begin
          clen = {b, clen[31:8]};
        end
        if (pos == 4'd7) begin
          pos = '0;
          cleft = clen;
          if (kind == KIND_DATA) begin
            got_data = 1'b1;
            nsamp = '0;
            held = '0;
          end
          walk = (clen == 32'd0) ? AT_CHUNK_HDR : AT_BODY;
        end else begin
          pos = pos + 4'd1;
        end
      end
      AT_BODY: begin
        off = clen - cleft;
        if (kind == KIND_FMT && clen >= 32'd16 && off < 32'd16) begin
          case (off[3:0])
            4'd0:  fcode[7:0] = b;
            4'd1:  fcode[15:8] = b;
            4'd2:  fchan[7:0] = b;
            4'd3:  fchan[15:8] = b;
            4'd4:  frate[7:0] = b;
            4'd5:  frate[15:8] = b;
            4'd6:  frate[23:16] = b;
            4'd7:  frate[31:24] = b;
            4'd14: fbits[7:0] = b;
            4'd15: begin
              fbits[15:8] = b;
              got_fmt = 1'b1;
            end
            default: ;
          endcase
        end else if (kind == KIND_DATA) begin
          if (held[8]) begin
            r = '0;
            r.sample_value = {b, held[7:0]};
            r.chunk_start = (nsamp == 32'd0);
            parser_outputs.push_back(r);
            nsamp = nsamp + 32'd1;
            held = '0;
          end else begin
            held = {1'b1, b};
          end
        end
        cleft = cleft - 32'd1;
        if (cleft == 32'd0) walk = clen[0] ? AT_PAD : AT_CHUNK_HDR;
      end
      AT_PAD: begin
        walk = AT_CHUNK_HDR;
        pos = '0;
      end
      default: ;
    endcase

    if (eof) begin
      r = '0;
      r.is_status = 1'b1;
      r.last_result = 1'b1;
      if (walk == AT_HEADER) r.status_code = ST_NOT_RIFF;
      else if (walk == AT_DEAD) r.status_code = hdr_err;
      else if (!got_fmt) r.status_code = ST_NO_FMT;
      else if (!got_data) r.status_code = ST_NO_DATA;
      else if (fcode != PCM_FORMAT || fbits != PCM_BITS) r.status_code = ST_UNSUPPORTED;
      else r.status_code = ST_OK;
      r.channel_count = fchan;
      r.sample_rate_hz = frate;
      r.total_samples = nsamp;
      parser_outputs.push_back(r);
      clear_parse();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // File assembly

  logic [7:0] file_bytes[$];

  function automatic void add_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void add_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(t[8*i +: 8]);
  endfunction

  function automatic void add_noise(input int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic void add_head(input logic [31:0] t, input logic [31:0] len);
    add_tag(t);
    add_le(len, 4);
  endfunction

  function automatic void add_riff(input logic [31:0] riff, input logic [31:0] wave);
    add_tag(riff);
    add_le($urandom, 4);
    add_tag(wave);
  endfunction

  function automatic void add_fmt(input int len, input logic [15:0] code,
                                  input logic [15:0] chans, input logic [31:0] rate,
                                  input logic [15:0] bits);
    add_head(TAG_FMT, len);
    if (len >= 16) begin
      add_le(32'(code), 2);
      add_le(32'(chans), 2);
      add_le(rate, 4);
      add_noise(6);      // byte rate and block align are not looked at
      add_le(32'(bits), 2);
      add_noise(len - 16);
    end else begin
      add_noise(len);
    end
    if (len % 2) add_noise(1);
  endfunction

  function automatic void add_other(input logic [31:0] t, input int len);
    add_head(t, len);
    add_noise(len + len % 2);
  endfunction

  function automatic void add_data(input int len);
    add_other(TAG_DATA, len);
  endfunction

  function automatic void trim_file(input int n);
    while (file_bytes.size() > n) void'(file_bytes.pop_back());
  endfunction

  function automatic void add_pcm_fmt();
    add_fmt(16, PCM_FORMAT, 16'd2, 32'd44100, PCM_BITS);
  endfunction

  typedef enum logic [4:0] {
    SC_EOF_FIRST, SC_SHORT_HDR, SC_BAD_RIFF, SC_BAD_BOTH, SC_BAD_WAVE, SC_HDR_ONLY,
    SC_NO_DATA, SC_PCM_EXTREMES, SC_DATA_FIRST, SC_SHORT_FMT, SC_FMT_FLOAT,
    SC_BITS_8, SC_FMT_TWICE, SC_DATA_TWICE, SC_ODD_DATA, SC_ODD_OTHER,
    SC_EMPTY_DATA, SC_CUT_FMT, SC_CUT_CHDR, SC_EOF_ON_SAMPLE, SC_LONG_FMT,
    SC_HUGE_DATA, SC_EOF_ON_PAD, SC_ZERO_FMT
  } scenario_t;

  // typed rows carry a status with zero channels, rate and count
  typedef struct packed {
    scenario_t  scenario;
    logic       typed;
    logic [2:0] want;
  } file_case_t;

  file_case_t plan [24] = '{
    '{SC_EOF_FIRST,     1'b1, ST_NOT_RIFF},
    '{SC_SHORT_HDR,     1'b1, ST_NOT_RIFF},
    '{SC_BAD_RIFF,      1'b1, ST_NOT_RIFF},
    '{SC_BAD_BOTH,      1'b1, ST_NOT_RIFF},
    '{SC_BAD_WAVE,      1'b1, ST_NOT_WAVE},
    '{SC_HDR_ONLY,      1'b1, ST_NO_FMT},
    '{SC_NO_DATA,       1'b0, ST_OK},
    '{SC_PCM_EXTREMES,  1'b0, ST_OK},
    '{SC_DATA_FIRST,    1'b0, ST_OK},
    '{SC_SHORT_FMT,     1'b0, ST_OK},
    '{SC_FMT_FLOAT,     1'b0, ST_OK},
    '{SC_BITS_8,        1'b0, ST_OK},
    '{SC_FMT_TWICE,     1'b0, ST_OK},
    '{SC_DATA_TWICE,    1'b0, ST_OK},
    '{SC_ODD_DATA,      1'b0, ST_OK},
    '{SC_ODD_OTHER,     1'b0, ST_OK},
    '{SC_EMPTY_DATA,    1'b0, ST_OK},
    '{SC_CUT_FMT,       1'b0, ST_OK},
    '{SC_CUT_CHDR,      1'b0, ST_OK},
    '{SC_EOF_ON_SAMPLE, 1'b0, ST_OK},
    '{SC_LONG_FMT,      1'b0, ST_OK},
    '{SC_HUGE_DATA,     1'b0, ST_OK},
    '{SC_EOF_ON_PAD,    1'b0, ST_OK},
    '{SC_ZERO_FMT,      1'b0, ST_OK}
  };

  function automatic void build_directed(input scenario_t sc);
    if (sc != SC_EOF_FIRST) add_riff(TAG_RIFF, TAG_WAVE);
    case (sc)
      SC_EOF_FIRST: begin
        add_tag(TAG_RIFF);
        trim_file(1);
      end
      SC_SHORT_HDR: trim_file(11);
      SC_BAD_RIFF: begin
        file_bytes.delete();
        add_riff(TAG_RIFF ^ 32'h1, TAG_WAVE);
      end
      SC_BAD_BOTH: begin
        file_bytes.delete();
        add_riff(32'h0, 32'hFFFF_FFFF);
        add_noise(6);
      end
      SC_BAD_WAVE: begin
        file_bytes.delete();
        add_riff(TAG_RIFF, TAG_WAVE ^ 32'h100);
        add_pcm_fmt();
        add_data(4);
      end
      SC_HDR_ONLY: ;
      SC_NO_DATA: add_pcm_fmt();
      SC_PCM_EXTREMES: begin
        add_fmt(16, PCM_FORMAT, 16'd1, 32'd48000, PCM_BITS);
        add_head(TAG_DATA, 32'd12);
        add_le(32'h7FFF_8000, 4);
        add_le(32'hFFFF_0000, 4);
        add_le(32'hFF00_00FF, 4);
      end
      SC_DATA_FIRST: begin
        add_data(6);
        add_pcm_fmt();
      end
      SC_SHORT_FMT: begin
        add_fmt(14, PCM_FORMAT, 16'd2, 32'd8000, PCM_BITS);
        add_data(4);
      end
      SC_FMT_FLOAT: begin
        add_fmt(16, 16'd3, 16'd2, 32'd96000, 16'd32);
        add_data(4);
      end
      SC_BITS_8: begin
        add_fmt(16, PCM_FORMAT, 16'd1, 32'd8000, 16'd8);
        add_data(4);
      end
      SC_FMT_TWICE: begin
        add_fmt(16, PCM_FORMAT, 16'd1, 32'd8000, PCM_BITS);
        add_data(4);
        add_fmt(16, PCM_FORMAT, 16'hFFFF, 32'hFFFF_FFFF, PCM_BITS);
      end
      SC_DATA_TWICE: begin
        add_pcm_fmt();
        add_data(6);
        add_data(4);
      end
      SC_ODD_DATA: begin
        add_pcm_fmt();
        add_data(5);
        add_other(TAG_LIST, 2);
      end
      SC_ODD_OTHER: begin
        add_other(TAG_LIST, 3);
        add_other(32'hFFFF_FFFF, 0);
        add_pcm_fmt();
        add_data(2);
      end
      SC_EMPTY_DATA: begin
        add_pcm_fmt();
        add_data(0);
      end
      SC_CUT_FMT: begin
        // ends six bytes into the fmt body: fields partly overwritten
        add_fmt(16, PCM_FORMAT, 16'h1234, 32'h89AB_CDEF, PCM_BITS);
        trim_file(26);
      end
      SC_CUT_CHDR: begin
        add_pcm_fmt();
        add_data(4);
        add_head(TAG_DATA, 32'd8);
        trim_file(file_bytes.size() - 3);
      end
      SC_EOF_ON_SAMPLE: begin
        add_pcm_fmt();
        add_data(4);
      end
      SC_LONG_FMT: begin
        add_fmt(19, PCM_FORMAT, 16'd6, 32'd32000, PCM_BITS);
        add_data(4);
      end
      SC_HUGE_DATA: begin
        add_pcm_fmt();
        add_head(TAG_DATA, 32'hFFFF_FFFF);
        add_noise(6);
      end
      SC_EOF_ON_PAD: begin
        add_pcm_fmt();
        add_data(5);
      end
      SC_ZERO_FMT: begin
        add_fmt(16, 16'd0, 16'd0, 32'd0, 16'd0);
        add_data(2);
      end
      default: ;
    endcase
  endfunction

  function automatic void build_random_file();
    int pick;
    logic [31:0] riff_tag;
    logic [31:0] wave_tag;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      add_noise($urandom_range(1, 30));
      return;
    end
    riff_tag = TAG_RIFF;
    wave_tag = TAG_WAVE;
    if (pick < 12) riff_tag ^= 32'h1 << $urandom_range(0, 31);
    else if (pick < 16) wave_tag ^= 32'h1 << $urandom_range(0, 31);
    add_riff(riff_tag, wave_tag);
    repeat ($urandom_range(1, 5)) begin
      pick = $urandom_range(0, 9);
      if (pick < 3)
        add_fmt(($urandom_range(0, 4) == 0) ? $urandom_range(0, 24) : 16,
                ($urandom_range(0, 7) == 0) ? 16'($urandom) : PCM_FORMAT,
                ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 8)),
                $urandom,
                ($urandom_range(0, 7) == 0) ? 16'($urandom) : PCM_BITS);
      else if (pick < 7)
        add_data(($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12));
      else if (pick < 9)
        add_other($urandom, $urandom_range(0, 9));
      else
        add_other(TAG_DATA ^ (32'h1 << $urandom_range(0, 31)), $urandom_range(0, 9));
    end
    if ($urandom_range(0, 6) == 0) trim_file($urandom_range(1, file_bytes.size()));
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned files_sent = 0;

  function automatic int draw_wait(input bit steady);
    return steady ? 0 : $urandom_range(0, 9);
  endfunction

  // valid stays high after acceptance so back-to-back items need no toggle
  task automatic send_byte(input logic [7:0] b, input logic eof);
    int gap;
    gap = draw_wait(tx_steady);
    if (gap != 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= '{data_byte: b, end_of_file: eof};
    do @(posedge clk); while (!byte_ready);
    parse_byte(b, eof);
    bytes_sent++;
  endtask

  task automatic send_file();
    int last;
    last = file_bytes.size() - 1;
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i <= last; i++) send_byte(file_bytes[i], i == last);
    file_bytes.delete();
    files_sent++;
  endtask

  task automatic wait_drained();
    byte_valid <= 1'b0;
    do @(posedge clk); while (parser_outputs.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver and checker

  int unsigned fail_count = 0;
  int unsigned samples_seen = 0;
  int unsigned status_seen = 0;
  int unsigned bad_status_seen = 0;

  task automatic flag_mismatch(input string msg);
    fail_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic cmp(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  task automatic check_result(input result_item_t got);
    result_item_t want;
    if (parser_outputs.size() == 0) begin
      flag_mismatch($sformatf("result 0x%0h with nothing pending", got));
    end else begin
      want = parser_outputs.pop_front();
      cmp("is_status", 32'(got.is_status), 32'(want.is_status));
      cmp("sample_value", 32'(got.sample_value), 32'(want.sample_value));
      cmp("chunk_start", 32'(got.chunk_start), 32'(want.chunk_start));
      cmp("status_code", 32'(got.status_code), 32'(want.status_code));
      cmp("channel_count", 32'(got.channel_count), 32'(want.channel_count));
      cmp("sample_rate_hz", got.sample_rate_hz, want.sample_rate_hz);
      cmp("total_samples", got.total_samples, want.total_samples);
      cmp("last_result", 32'(got.last_result), 32'(want.last_result));
      if (want.is_status) begin
        status_seen++;
        if (want.status_code != ST_OK) bad_status_seen++;
      end else begin
        samples_seen++;
      end
    end
  endtask

  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = draw_wait(rx_steady);
      if (stall != 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
      check_result(result_item);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence

  initial begin
    result_item_t typed_status;
    int unsigned random_goal;
    clear_parse();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      build_directed(plan[i].scenario);
      send_file();
      if (plan[i].typed) begin
        // replace the mirrored status with the hand-written one
        void'(parser_outputs.pop_back());
        typed_status = '0;
        typed_status.is_status = 1'b1;
        typed_status.last_result = 1'b1;
        typed_status.status_code = plan[i].want;
        parser_outputs.push_back(typed_status);
      end
    end
    wait_drained();

    random_goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < random_goal) begin
      build_random_file();
      send_file();
      if (files_sent % 6 == 0) wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);

    $display("Ran %0d files (%0d bytes): %0d samples and %0d status items checked",
             files_sent, bytes_sent, samples_seen, status_seen);
    $display("%0d of those files ended in an error status", bad_status_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/wpsp_pkg.sv
hdl/wpsp_front.sv
hdl/wpsp_queue.sv
hdl/wpsp_back.sv
hdl/wav_pcm16_stream_parser.sv
tb/tb_wav_pcm16_stream_parser.sv
